### hw/rtl/tpg_pkg.sv
// Package with shared widths, codes and reset values of the timeline phase generator.
`default_nettype none

package tpg_pkg;

  // Fixed field widths.
  localparam int MODE_W     = 3;
  localparam int DELTA_W    = 16;
  localparam int DUR_W      = 24;
  localparam int KIND_W     = 2;
  localparam int RATE_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int ELAPSED_W  = 32;
  localparam int DELAY_W    = 25;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Default fraction widths.
  localparam int PHASE_FRAC_BITS = 16;
  localparam int SPEED_FRAC_BITS = 8;

  // Command codes.
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PLAY    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RESUME  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RESTART = 3'd5;

  // Run states as reported on the result.
  localparam logic [STATUS_W-1:0] RS_IDLE      = 2'd0;
  localparam logic [STATUS_W-1:0] RS_PLAYING   = 2'd1;
  localparam logic [STATUS_W-1:0] RS_PAUSED    = 2'd2;
  localparam logic [STATUS_W-1:0] RS_COMPLETED = 2'd3;

  // Loop kinds.
  localparam logic [KIND_W-1:0] LK_ONCE = 2'd0;
  localparam logic [KIND_W-1:0] LK_LOOP = 2'd1;
  localparam logic [KIND_W-1:0] LK_PING = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_KIND   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE        = 4'd3;

  // Register reset values.
  localparam logic [DUR_W-1:0]  DURATION_RST    = 24'd1000;
  localparam logic [DUR_W-1:0]  START_DELAY_RST = 24'd0;
  localparam logic [KIND_W-1:0] LOOP_KIND_RST   = LK_ONCE;
  localparam logic [RATE_W-1:0] RATE_RST        = 16'd256;

endpackage

`default_nettype wire

### hw/rtl/tpg_ifs.sv
// Handshake interfaces for the command, result and configuration channels.
`default_nettype none

interface tpg_cmd_if;
  import tpg_pkg::*;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [DELTA_W-1:0] delta_time;
  logic               owner_valid;

  modport source (output valid, mode, delta_time, owner_valid, input ready);
  modport sink   (input valid, mode, delta_time, owner_valid, output ready);
endinterface

interface tpg_res_if #(
  parameter int PhaseFracBits = tpg_pkg::PHASE_FRAC_BITS
);
  import tpg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PhaseFracBits:0] phase;
  logic                  phase_valid;
  logic                  started;
  logic                  completed;
  logic [STATUS_W-1:0]   run_status;

  modport source (output valid, phase, phase_valid, started, completed, run_status,
                  input ready);
  modport sink   (input valid, phase, phase_valid, started, completed, run_status,
                  output ready);
endinterface

interface tpg_cfg_if;
  import tpg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/timeline_phase_generator.sv
// Timeline controller: run state, delay and elapsed counters, phase by a shared divider.
// One item is in work at a time; its result is registered as the block returns to idle. A
// control command, an ignored tick or a tick in the start delay goes straight to the result;
// a tick that ends a once-mode pass or meets a zero duration goes through multiply, add and
// compare; a phase tick then divides out the fraction, after the remainder if the pass wraps.
// A stall on the result holds the item. Synchronous reset restores defaults and idle.
`default_nettype none

module timeline_phase_generator #(
  parameter int PhaseFracBits = tpg_pkg::PHASE_FRAC_BITS,
  parameter int SpeedFracBits = tpg_pkg::SPEED_FRAC_BITS
) (
  input  wire       clk,
  input  wire       rst,
  tpg_cmd_if.sink   cmd,
  tpg_res_if.source res,
  tpg_cfg_if.sink   cfg
);
  import tpg_pkg::*;

  localparam int D_W    = DUR_W + SpeedFracBits;
  localparam int WIDE_W = (ELAPSED_W > D_W ? ELAPSED_W : D_W) + 1;
  localparam int CNT_W  = $clog2(ELAPSED_W > PhaseFracBits ? ELAPSED_W : PhaseFracBits);
  localparam logic [PhaseFracBits:0] ONE = {1'b1, {PhaseFracBits{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ADD, S_CMP, S_MOD, S_FRAC, S_EMIT
  } seq_state_t;

  seq_state_t state;

  // Configuration registers.
  logic [DUR_W-1:0]  duration;
  logic [DUR_W-1:0]  start_delay;
  logic [KIND_W-1:0] loop_kind;
  logic [RATE_W-1:0] rate;

  // Timeline state.
  logic [STATUS_W-1:0]  run_state;
  logic [ELAPSED_W-1:0] elapsed;
  logic [DELAY_W-1:0]   delay_count;
  logic                 bounce_reversed;
  logic                 start_done;

  // Working registers of the current item.
  logic [DELTA_W-1:0]       delta;
  logic [ELAPSED_W-1:0]     prod;
  logic [WIDE_W-1:0]        rem;
  logic [PhaseFracBits-1:0] quot;
  logic [PhaseFracBits:0]   raw;
  logic [CNT_W-1:0]         cnt;
  logic                     flag_valid;
  logic                     flag_started;
  logic                     flag_completed;

  // Result register.
  logic                   res_valid;
  logic [PhaseFracBits:0] res_phase;
  logic                   res_phase_valid;
  logic                   res_started;
  logic                   res_completed;
  logic [STATUS_W-1:0]    res_run_status;

  // Combinational helpers.
  logic [RATE_W-1:0]    mag;
  logic [D_W-1:0]       dsc;
  logic [WIDE_W-1:0]    dsc_wide;
  logic [WIDE_W-1:0]    elapsed_wide;
  logic [DELAY_W:0]     delay_sum;
  logic [DELAY_W-1:0]   delay_sat;
  logic [ELAPSED_W:0]   elapsed_sum;
  logic [WIDE_W-1:0]    step_in;
  logic                 step_take;
  logic [WIDE_W-1:0]    step_out;
  logic                 is_loop;
  logic                 rev;
  logic [PhaseFracBits:0] phase_out;

  assign mag          = rate[RATE_W-1] ? RATE_W'(RATE_W'(0) - rate) : rate;
  assign dsc          = {duration, {SpeedFracBits{1'b0}}};
  assign dsc_wide     = {{(WIDE_W - D_W){1'b0}}, dsc};
  assign elapsed_wide = {{(WIDE_W - ELAPSED_W){1'b0}}, elapsed};
  assign delay_sum    = {1'b0, delay_count} + {{(DELAY_W + 1 - DELTA_W){1'b0}}, cmd.delta_time};
  assign delay_sat    = delay_sum[DELAY_W] ? {DELAY_W{1'b1}} : delay_sum[DELAY_W-1:0];
  assign elapsed_sum  = {1'b0, elapsed} + {1'b0, prod};
  assign is_loop      = (loop_kind == LK_LOOP) || (loop_kind == LK_PING);

  // Shared shift-compare-subtract step: remainder pass feeds elapsed bits, fraction feeds zeros.
  always_comb begin
    step_in   = {rem[WIDE_W-2:0], (state == S_MOD) ? elapsed[ELAPSED_W-1] : 1'b0};
    step_take = (step_in >= dsc_wide);
    step_out  = step_take ? step_in - dsc_wide : step_in;
  end

  // Mirror the phase for negative speed XOR the ping-pong direction.
  assign rev       = rate[RATE_W-1] ^ bounce_reversed;
  assign phase_out = flag_valid ? (rev ? ONE - raw : raw) : '0;

  assign cmd.ready      = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign res.valid       = res_valid;
  assign res.phase       = res_phase;
  assign res.phase_valid = res_phase_valid;
  assign res.started     = res_started;
  assign res.completed   = res_completed;
  assign res.run_status  = res_run_status;

  // Sequencer, timeline state, configuration and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      duration        <= DURATION_RST;
      start_delay     <= START_DELAY_RST;
      loop_kind       <= LOOP_KIND_RST;
      rate            <= RATE_RST;
      run_state       <= RS_IDLE;
      elapsed         <= '0;
      delay_count     <= '0;
      bounce_reversed <= 1'b0;
      start_done      <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      // Register writes must arrive only while the block is idle; the block itself does not enforce it.
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_DURATION:    duration    <= cfg.data[DUR_W-1:0];
          CFG_START_DELAY: start_delay <= cfg.data[DUR_W-1:0];
          CFG_LOOP_KIND:   loop_kind   <= cfg.data[KIND_W-1:0];
          CFG_RATE:        rate        <= cfg.data[RATE_W-1:0];
          default: ;
        endcase
      end

      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            delta          <= cmd.delta_time;
            flag_valid     <= 1'b0;
            flag_started   <= 1'b0;
            flag_completed <= 1'b0;
            state          <= S_EMIT;
            unique case (cmd.mode) inside
              MODE_PLAY, MODE_RESTART, MODE_STOP: begin
                elapsed         <= '0;
                delay_count     <= '0;
                bounce_reversed <= 1'b0;
                start_done      <= 1'b0;
                run_state       <= (cmd.mode == MODE_STOP) ? RS_IDLE : RS_PLAYING;
              end
              MODE_PAUSE: begin
                if (run_state == RS_PLAYING) run_state <= RS_PAUSED;
              end
              MODE_RESUME: begin
                if (run_state == RS_PAUSED) run_state <= RS_PLAYING;
              end
              MODE_TICK: begin
                if (run_state == RS_PLAYING) begin
                  if (!cmd.owner_valid) begin
                    // Target gone: behave as stop.
                    elapsed         <= '0;
                    delay_count     <= '0;
                    bounce_reversed <= 1'b0;
                    start_done      <= 1'b0;
                    run_state       <= RS_IDLE;
                  end else if (start_done) begin
                    state <= S_MUL;
                  end else begin
                    // Count the start delay; the whole delta also runs once it ends.
                    delay_count <= delay_sat;
                    if (delay_sat >= {{(DELAY_W - DUR_W){1'b0}}, start_delay}) begin
                      start_done   <= 1'b1;
                      flag_started <= 1'b1;
                      state        <= S_MUL;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_MUL: begin
          prod  <= ELAPSED_W'(delta * mag);
          state <= S_ADD;
        end

        S_ADD: begin
          elapsed <= elapsed_sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : elapsed_sum[ELAPSED_W-1:0];
          state   <= S_CMP;
        end

        S_CMP: begin
          flag_valid <= 1'b1;
          if ((dsc == '0) || (elapsed_wide >= dsc_wide)) begin
            if (is_loop) begin
              if (loop_kind == LK_PING) bounce_reversed <= ~bounce_reversed;
              if (dsc == '0) begin
                elapsed <= '0;
                raw     <= ONE;
                state   <= S_EMIT;
              end else begin
                rem   <= '0;
                cnt   <= CNT_W'(ELAPSED_W - 1);
                state <= S_MOD;
              end
            end else begin
              raw            <= ONE;
              run_state      <= RS_COMPLETED;
              flag_completed <= 1'b1;
              state          <= S_EMIT;
            end
          end else begin
            rem   <= elapsed_wide;
            quot  <= '0;
            cnt   <= CNT_W'(PhaseFracBits - 1);
            state <= S_FRAC;
          end
        end

        // Remainder of elapsed by the scaled duration, one bit per cycle.
        S_MOD: begin
          rem     <= step_out;
          elapsed <= {elapsed[ELAPSED_W-2:0], 1'b0};
          cnt     <= cnt - 1'b1;
          if (cnt == '0) begin
            elapsed <= step_out[ELAPSED_W-1:0];
            quot    <= '0;
            cnt     <= CNT_W'(PhaseFracBits - 1);
            state   <= S_FRAC;
          end
        end

        // Phase fraction, one quotient bit per cycle.
        S_FRAC: begin
          rem  <= step_out;
          quot <= {quot[PhaseFracBits-2:0], step_take};
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            raw   <= {1'b0, quot[PhaseFracBits-2:0], step_take};
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (!res_valid || res.ready) begin
            res_valid       <= 1'b1;
            res_phase       <= phase_out;
            res_phase_valid <= flag_valid;
            res_started     <= flag_started;
            res_completed   <= flag_completed;
            res_run_status  <= run_state;
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the timeline phase generator.
`timescale 1ns / 100ps

module tb;
  import tpg_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int TAIL_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 1280;
  localparam int REPORT_LIMIT   = 10;

  // Command codes the block must ignore.
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
  // The fourth loop kind, which behaves as once.
  localparam logic [KIND_W-1:0] LK_SPARE = 2'd3;
  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

  localparam logic [DUR_W-1:0]  DUR_MAX        = '1;
  localparam logic [RATE_W-1:0] RATE_NEG_UNITY = 16'hFF00;
  localparam logic [RATE_W-1:0] RATE_NEG_MAX   = 16'h8000;
  localparam logic [RATE_W-1:0] RATE_POS_MAX   = 16'h7FFF;
  localparam logic [RATE_W-1:0] RATE_ZERO      = 16'h0000;
  localparam logic [DELTA_W-1:0] DELTA_MAX     = '1;

  localparam longint unsigned ELAPSED_SAT = (64'd1 << ELAPSED_W) - 1;
  localparam longint unsigned DELAY_SAT   = (64'd1 << DELAY_W) - 1;

  typedef struct packed {
    logic [PHASE_FRAC_BITS:0] phase;
    logic                     phase_valid;
    logic                     started;
    logic                     completed;
    logic [STATUS_W-1:0]      status;
  } timeline_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tpg_cmd_if cmd_bus ();
  tpg_res_if res_bus ();
  tpg_cfg_if cfg_bus ();

  timeline_phase_generator uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  // Free-running clock.
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow registers and timeline state kept by the predictor.
  logic [DUR_W-1:0]     cfg_duration;
  logic [DUR_W-1:0]     cfg_start_delay;
  logic [KIND_W-1:0]    cfg_loop_kind;
  logic [RATE_W-1:0]    cfg_rate;
  logic [STATUS_W-1:0]  tl_state;
  logic [ELAPSED_W-1:0] tl_elapsed;
  logic [DELAY_W-1:0]   tl_delay;
  logic                 tl_bounce;
  logic                 tl_start_done;

  timeline_result_t pending_results[$];

  int error_count    = 0;
  int accepted_count = 0;
  int acted_count    = 0;
  int phase_beats    = 0;
  int start_pulses   = 0;
  int completions    = 0;
  int settings_count = 0;
  int burst_left     = 0;
  int hold_request   = 0;
  bit gaps_on        = 1'b1;

  function automatic void clear_timeline(input logic [STATUS_W-1:0] next_state);
    tl_elapsed    = '0;
    tl_delay      = '0;
    tl_bounce     = 1'b0;
    tl_start_done = 1'b0;
    tl_state      = next_state;
  endfunction

  // Works out the result of one command and updates the shadow timeline.
  // The acted flag is cleared when the command leaves the timeline untouched.
  function automatic timeline_result_t advance_timeline(input logic [MODE_W-1:0] mode,
                                                        input logic [DELTA_W-1:0] delta,
                                                        input logic owner,
                                                        output bit acted);
    timeline_result_t r;
    longint unsigned one_q, mag, dscaled, esum, dsum, raw, ph;
    bit neg, go;
    one_q = 64'd1 << PHASE_FRAC_BITS;
    r     = '0;
    acted = 1'b1;
    case (mode) inside
      MODE_PLAY, MODE_RESTART: clear_timeline(RS_PLAYING);
      MODE_STOP:               clear_timeline(RS_IDLE);
      MODE_PAUSE: begin
        if (tl_state == RS_PLAYING) tl_state = RS_PAUSED;
        else acted = 1'b0;
      end
      MODE_RESUME: begin
        if (tl_state == RS_PAUSED) tl_state = RS_PLAYING;
        else acted = 1'b0;
      end
      MODE_TICK: begin
        if (tl_state != RS_PLAYING) begin
          acted = 1'b0;
        end else if (!owner) begin
          clear_timeline(RS_IDLE);
        end else begin
          go = 1'b1;
          // Count the start delay first; the tick that ends it also advances time.
          if (!tl_start_done) begin
            dsum = 64'(tl_delay);
            dsum = dsum + delta;
            if (dsum > DELAY_SAT) dsum = DELAY_SAT;
            tl_delay = dsum[DELAY_W-1:0];
            if (dsum < cfg_start_delay) begin
              go = 1'b0;
            end else begin
              tl_start_done = 1'b1;
              r.started     = 1'b1;
            end
          end
          if (go) begin
            neg     = cfg_rate[RATE_W-1];
            mag     = neg ? (64'd65536 - cfg_rate) : cfg_rate;
            dscaled = 64'(cfg_duration);
            dscaled = dscaled << SPEED_FRAC_BITS;
            esum    = 64'(tl_elapsed);
            esum    = esum + delta * mag;
            if (esum > ELAPSED_SAT) esum = ELAPSED_SAT;
            if (dscaled == 0 || esum >= dscaled) begin
              if (cfg_loop_kind == LK_LOOP || cfg_loop_kind == LK_PING) begin
                if (dscaled == 0) begin
                  esum = 0;
                  raw  = one_q;
                end else begin
                  esum = esum % dscaled;
                  raw  = (esum << PHASE_FRAC_BITS) / dscaled;
                end
                if (cfg_loop_kind == LK_PING) tl_bounce = !tl_bounce;
              end else begin
                raw         = one_q;
                tl_state    = RS_COMPLETED;
                r.completed = 1'b1;
              end
            end else begin
              raw = (esum << PHASE_FRAC_BITS) / dscaled;
            end
            tl_elapsed    = esum[ELAPSED_W-1:0];
            ph            = (neg != tl_bounce) ? one_q - raw : raw;
            r.phase       = ph[PHASE_FRAC_BITS:0];
            r.phase_valid = 1'b1;
          end
        end
      end
      default: acted = 1'b0;
    endcase
    r.status = tl_state;
    return r;
  endfunction

  // Offers one command beat, in bursts with random gaps, and records its prediction.
  task automatic send_command(input logic [MODE_W-1:0] mode, input logic [DELTA_W-1:0] delta,
                              input logic owner);
    timeline_result_t want;
    bit acted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = 0;
      if (gaps_on && $urandom_range(0, 2) != 0)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
      if (gap != 0) begin
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cmd_bus.valid       <= 1'b1;
    cmd_bus.mode        <= mode;
    cmd_bus.delta_time  <= delta;
    cmd_bus.owner_valid <= owner;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    want = advance_timeline(mode, delta, owner, acted);
    pending_results.push_back(want);
    accepted_count++;
    if (acted) acted_count++;
    if (want.phase_valid) phase_beats++;
    if (want.started) start_pulses++;
    if (want.completed) completions++;
    @(negedge clk);
  endtask

  // Writes one register; valid drops again after the write is taken, before the next write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      CFG_DURATION:    cfg_duration    = value[DUR_W-1:0];
      CFG_START_DELAY: cfg_start_delay = value[DUR_W-1:0];
      CFG_LOOP_KIND:   cfg_loop_kind   = value[KIND_W-1:0];
      CFG_RATE:        cfg_rate        = value[RATE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stops offering commands and waits until every result is in and the block is quiet.
  task automatic drain_results();
    cmd_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  function automatic logic [DELTA_W-1:0] rand_delta();
    case ($urandom_range(0, 9))
      0, 1:    return DELTA_W'($urandom_range(0, 63));
      2, 3:    return DELTA_W'($urandom_range(0, 1023));
      4:       return ($urandom_range(0, 1) != 0) ? DELTA_MAX : '0;
      default: return DELTA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] rand_duration();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return DUR_MAX;
      2, 3, 4, 5: return DUR_W'($urandom_range(1, 200));
      6, 7, 8:    return DUR_W'($urandom_range(1, 20000));
      default:    return DUR_W'($urandom_range(0, 32'hFF_FFFF));
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] rand_rate();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 6) return RATE_RST;
    if (pick < 9) return RATE_NEG_UNITY;
    if (pick < 11) return RATE_NEG_MAX;
    if (pick < 12) return RATE_POS_MAX;
    if (pick < 13) return RATE_ZERO;
    if (pick < 14)
      return RATE_W'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 16)
                                                  : -$urandom_range(1, 16));
    return RATE_W'($urandom_range(0, 65535));
  endfunction

  // Picks a new setting for a random subset of registers, now and then a spare index too.
  task automatic randomise_settings();
    logic [3:0] mask;
    logic [CFG_DATA_W-1:0] upper;
    logic [DUR_W-1:0] dly;
    mask  = 4'($urandom_range(1, 15));
    upper = CFG_DATA_W'($urandom);
    if (mask[0]) write_register(CFG_DURATION, rand_duration());
    if (mask[1]) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: dly = '0;
        6, 7, 8:          dly = DUR_W'($urandom_range(1, 2000));
        default:          dly = DUR_W'($urandom_range(2001, 200000));
      endcase
      write_register(CFG_START_DELAY, dly);
    end
    if (mask[2]) write_register(CFG_LOOP_KIND, {upper[CFG_DATA_W-1:KIND_W],
                                                KIND_W'($urandom_range(0, 3))});
    if (mask[3]) write_register(CFG_RATE, {upper[CFG_DATA_W-1:RATE_W], rand_rate()});
    if ($urandom_range(0, 7) == 0)
      write_register(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                     CFG_DATA_W'($urandom));
    settings_count++;
  endtask

  // Control commands under the reset settings, including ignored ones.
  task automatic test_control_commands();
    send_command(MODE_TICK, DELTA_MAX, 1'b1);
    send_command(MODE_PAUSE, '0, 1'b1);
    send_command(MODE_UNUSED_LO, DELTA_MAX, 1'b1);
    send_command(MODE_UNUSED_HI, '0, 1'b0);
    send_command(MODE_PLAY, '0, 1'b0);
    send_command(MODE_TICK, '0, 1'b1);
    send_command(MODE_TICK, 16'd500, 1'b1);
    send_command(MODE_PAUSE, '0, 1'b1);
    send_command(MODE_TICK, 16'd100, 1'b1);
    send_command(MODE_RESUME, '0, 1'b1);
    send_command(MODE_RESUME, '0, 1'b1);
    send_command(MODE_TICK, DELTA_MAX, 1'b1);
    send_command(MODE_RESTART, '0, 1'b1);
    send_command(MODE_TICK, DELTA_MAX, 1'b0);
    send_command(MODE_STOP, '0, 1'b1);
    drain_results();
  endtask

  // Zero duration in once and ping-pong modes, with writes to spare indexes.
  task automatic test_zero_duration();
    write_register(CFG_SPARE_HI, '1);
    write_register(CFG_SPARE_LO, '1);
    write_register(CFG_DURATION, '0);
    write_register(CFG_LOOP_KIND, {{(CFG_DATA_W - KIND_W){1'b1}}, LK_ONCE});
    settings_count++;
    send_command(MODE_PLAY, '0, 1'b1);
    send_command(MODE_TICK, '0, 1'b1);
    drain_results();
    write_register(CFG_LOOP_KIND, CFG_DATA_W'(LK_PING));
    settings_count++;
    send_command(MODE_PLAY, '0, 1'b1);
    send_command(MODE_TICK, 16'd1, 1'b1);
    send_command(MODE_TICK, 16'd1, 1'b1);
    drain_results();
  endtask

  // Longest duration, extreme rates, a start delay and counter saturation.
  task automatic test_saturation_and_delay();
    write_register(CFG_DURATION, DUR_MAX);
    write_register(CFG_START_DELAY, 24'd70000);
    write_register(CFG_LOOP_KIND, CFG_DATA_W'(LK_SPARE));
    write_register(CFG_RATE, CFG_DATA_W'(RATE_NEG_MAX));
    settings_count++;
    send_command(MODE_PLAY, '0, 1'b1);
    repeat (4) send_command(MODE_TICK, DELTA_MAX, 1'b1);
    drain_results();
    write_register(CFG_START_DELAY, '0);
    write_register(CFG_LOOP_KIND, CFG_DATA_W'(LK_LOOP));
    write_register(CFG_RATE, CFG_DATA_W'(RATE_POS_MAX));
    settings_count++;
    send_command(MODE_PLAY, '0, 1'b1);
    repeat (3) send_command(MODE_TICK, DELTA_MAX, 1'b1);
    drain_results();
  endtask

  // The result side holds off for a long stretch while commands keep coming.
  task automatic test_backpressure();
    write_register(CFG_DURATION, 24'd200);
    write_register(CFG_LOOP_KIND, CFG_DATA_W'(LK_PING));
    write_register(CFG_RATE, CFG_DATA_W'(RATE_RST));
    settings_count++;
    gaps_on      = 1'b0;
    hold_request = HOLD_CYCLES;
    send_command(MODE_PLAY, '0, 1'b1);
    repeat (40) send_command(MODE_TICK, rand_delta(), 1'b1);
    gaps_on = 1'b1;
    drain_results();
  endtask

  // Random settings, each followed by a play or restart and a run of mostly ticks.
  task automatic test_random_timelines();
    int item_target;
    int ticks;
    int pick;
    logic [MODE_W-1:0] mode;
    logic owner;
    item_target = accepted_count + RANDOM_ITEMS;
    while (accepted_count < item_target) begin
      drain_results();
      randomise_settings();
      send_command(($urandom_range(0, 1) != 0) ? MODE_PLAY : MODE_RESTART, rand_delta(),
                   1'($urandom_range(0, 1)));
      ticks = $urandom_range(8, 60);
      repeat (ticks) begin
        pick  = $urandom_range(0, 99);
        owner = 1'b1;
        // Steer back into playing so that most beats exercise the tick path.
        if (tl_state == RS_PAUSED && pick < 50) mode = MODE_RESUME;
        else if ((tl_state == RS_COMPLETED || tl_state == RS_IDLE) && pick < 40)
          mode = (pick < 20) ? MODE_PLAY : MODE_RESTART;
        else if (pick < 84) mode = MODE_TICK;
        else if (pick < 87) begin
          mode  = MODE_TICK;
          owner = 1'b0;
        end
        else if (pick < 91) mode = MODE_PAUSE;
        else if (pick < 94) mode = MODE_RESUME;
        else if (pick < 96) mode = MODE_RESTART;
        else if (pick < 97) mode = MODE_STOP;
        else if (pick < 98) mode = MODE_PLAY;
        else mode = ($urandom_range(0, 1) != 0) ? MODE_UNUSED_LO : MODE_UNUSED_HI;
        send_command(mode, rand_delta(), owner);
      end
    end
    drain_results();
  endtask

  // Result receiver: stall patterns that change every so often, plus the requested hold-off.
  initial begin
    int hold_left;
    int stall_pct;
    int pattern_left;
    hold_left     = 0;
    stall_pct     = 0;
    pattern_left  = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 75;
        endcase
      end
      pattern_left--;
      if (hold_left != 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  // Result checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    timeline_result_t got;
    timeline_result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got.phase       = res_bus.phase;
      got.phase_valid = res_bus.phase_valid;
      got.started     = res_bus.started;
      got.completed   = res_bus.completed;
      got.status      = res_bus.run_status;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: result beat with nothing expected: phase=%0d pv=%0b st=%0b cp=%0b rs=%0d",
                   $realtime, got.phase, got.phase_valid, got.started, got.completed,
                   got.status);
      end else begin
        want = pending_results.pop_front();
        if (got.phase !== want.phase || got.phase_valid !== want.phase_valid ||
            got.started !== want.started || got.completed !== want.completed ||
            got.status !== want.status) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch, expected phase=%0d pv=%0b st=%0b cp=%0b rs=%0d",
                     $realtime, want.phase, want.phase_valid, want.started, want.completed,
                     want.status);
            $display("%0t:            got phase=%0d pv=%0b st=%0b cp=%0b rs=%0d",
                     $realtime, got.phase, got.phase_valid, got.started, got.completed,
                     got.status);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    int quiet_cycles;
    if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    cmd_bus.valid       = 1'b0;
    cmd_bus.mode        = MODE_TICK;
    cmd_bus.delta_time  = '0;
    cmd_bus.owner_valid = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = CFG_DURATION;
    cfg_bus.data        = '0;
    cfg_duration        = DURATION_RST;
    cfg_start_delay     = START_DELAY_RST;
    cfg_loop_kind       = LOOP_KIND_RST;
    cfg_rate            = RATE_RST;
    clear_timeline(RS_IDLE);
    rst = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_control_commands();
    test_zero_duration();
    test_saturation_and_delay();
    test_backpressure();
    test_random_timelines();

    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", pending_results.size());
    end
    $display("Summary: %0d commands accepted, %0d of them acting on the timeline, %0d settings.",
             accepted_count, acted_count, settings_count);
    $display("Summary: %0d phase beats, %0d start pulses, %0d completions; %0d failures.",
             phase_beats, start_pulses, completions, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tpg_pkg.sv
hw/rtl/tpg_ifs.sv
hw/rtl/timeline_phase_generator.sv
tb/tb.sv
